FILE: sv/cit_pkg.sv
`default_nettype none

package cit_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 32;
  localparam int ID_BYTES    = 5;

  // Port widths fixed by the interface.
  localparam int ID_W     = 40;
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 5;
  localparam int TOTAL_W  = 6;

  // Only the low ID_BYTES bytes of an identifier take part, never more than the port holds.
  localparam int KEY_W = (8 * ID_BYTES < ID_W) ? 8 * ID_BYTES : ID_W;

  // Slot index and count widths derived from the depth.
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMPACT,
    ST_RESP
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic             shift;
    logic             compact;
    logic [IDX_W-1:0] pos;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/cit_cell.sv
`default_nettype none

module cit_cell
  import cit_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [IDX_W-1:0] slot,
  input  wire logic [KEY_W-1:0] data_in,
  output logic      [KEY_W-1:0] data
);

  logic take;

  // A cell takes its right neighbor on every shift, and during compaction
  // only when it sits at or above the removed slot.
  assign take = ctrl.shift | (ctrl.compact & (slot >= ctrl.pos));

  // Stored identifier; payload, so no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      data <= data_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/card_id_table.sv
`default_nettype none

// card_id_table: packed list of card identifiers with add, find and delete.
//
// A request (req_type, card_id) transfers at a rising edge with start high
// and busy low. Exactly one result (status, entry_index, entry_total) follows,
// shown for one cycle with done high; the receiver takes it in that cycle and
// cannot stall it.
//
// The identifiers live in a chain of cells that rotates as a ring. A request
// rotates the ring once, comparing the head cell with the key; an add writes
// the new identifier into the tail as the first free slot passes. A delete
// that hits then passes through a compaction step in which every cell at or
// above the removed slot takes its neighbor. A table-full add and the unused
// request code skip the rotation.
// Done follows the rotation, or the compaction step for a delete that hits,
// and comes straight from idle when the rotation is skipped; a new request
// may transfer in the cycle after done, so the block takes no new request
// before it is through with the last one.
// Reset clears the count, so the table is empty; stored words are not cleared.

module card_id_table
  import cit_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [REQ_W-1:0]    req_type,
  input  wire logic [ID_W-1:0]     card_id,
  output logic                     done,
  output logic      [STATUS_W-1:0] status,
  output logic      [INDEX_W-1:0]  entry_index,
  output logic      [TOTAL_W-1:0]  entry_total
);

  state_t state, state_next;

  logic [REQ_W-1:0]    req_r;
  logic [KEY_W-1:0]    key;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    step;
  logic                found;
  logic [IDX_W-1:0]    pos;
  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_index;

  cell_ctrl_t          ctrl;
  logic [KEY_W-1:0]    cell_q [MAX_ENTRIES];
  logic [KEY_W-1:0]    feed;
  logic [KEY_W-1:0]    head;
  logic                hit;
  logic                last;
  logic                accept;
  logic                skip;
  logic                found_any;
  logic [IDX_W-1:0]    pos_any;

  // Chain of cells: each takes its right neighbor, the last one the feedback.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic [KEY_W-1:0] nb;
    if (k == MAX_ENTRIES - 1) begin : g_tail
      assign nb = feed;
    end else begin : g_mid
      assign nb = cell_q[k+1];
    end
    cit_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .slot    (IDX_W'(k)),
      .data_in (nb),
      .data    (cell_q[k])
    );
  end

  assign head      = cell_q[0];
  assign accept    = start && !busy;
  assign skip      = ((req_type == REQ_ADD) && (count >= CNT_W'(MAX_ENTRIES)))
                     || ((req_type != REQ_ADD) && (req_type != REQ_FIND)
                         && (req_type != REQ_DELETE));
  assign last      = (step == CNT_W'(MAX_ENTRIES - 1));
  assign hit       = (state == ST_SCAN) && (step < count) && !found && (head == key);
  assign found_any = found || hit;
  assign pos_any   = hit ? step[IDX_W-1:0] : pos;

  // Next state and chain control.
  always_comb begin
    state_next   = state;
    ctrl.shift   = 1'b0;
    ctrl.compact = 1'b0;
    ctrl.pos     = pos;
    feed         = head;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = skip ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        // The first free slot passes the head: an add without a match lands here.
        if ((req_r == REQ_ADD) && (step == count) && !found) begin
          feed = key;
        end
        if (last) begin
          state_next = ((req_r == REQ_DELETE) && found_any) ? ST_COMPACT : ST_RESP;
        end
      end
      ST_COMPACT: begin
        ctrl.compact = 1'b1;
        state_next   = ST_RESP;
      end
      ST_RESP: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        step <= step + CNT_W'(1);
        if (hit) begin
          found <= 1'b1;
        end
        if (last && (req_r == REQ_ADD) && !found_any) begin
          count <= count + CNT_W'(1);
        end
      end else if (state == ST_COMPACT) begin
        count <= count - CNT_W'(1);
      end else if (accept) begin
        step  <= '0;
        found <= 1'b0;
      end
    end
  end

  // Request capture and result registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= req_type;
      key        <= card_id[KEY_W-1:0];
      res_status <= (req_type == REQ_ADD) ? STAT_FULL : STAT_ABSENT;
      res_index  <= '0;
    end else if ((state == ST_SCAN) && last) begin
      if (req_r == REQ_ADD) begin
        if (found_any) begin
          res_status <= STAT_PRESENT;
          res_index  <= '0;
        end else begin
          res_status <= STAT_OK;
          res_index  <= count[IDX_W-1:0];
        end
      end else if (found_any) begin
        res_status <= STAT_OK;
        res_index  <= pos_any;
      end else begin
        res_status <= STAT_ABSENT;
        res_index  <= '0;
      end
    end
    if ((state == ST_SCAN) && hit) begin
      pos <= step[IDX_W-1:0];
    end
  end

  // Handshake and result ports.
  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_RESP);
  assign status      = res_status;
  assign entry_index = INDEX_W'(res_index);
  assign entry_total = TOTAL_W'(count);

  // The count never exceeds the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds table depth");

  // A refused or missed request reports slot zero.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STAT_OK)) |-> (entry_index == '0))
    else $error("nonzero index with failing status");

  // A successful add reports the slot just below the new count.
  a_add_slot: assert property (@(posedge clk) disable iff (rst)
    (done && (req_r == REQ_ADD) && (status == STAT_OK))
      |-> (CNT_W'(res_index) + CNT_W'(1) == count))
    else $error("added slot does not match new count");

  // Only the scan, compaction or a skipped request lead into a result.
  a_done_path: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || accept))
    else $error("result without a request in progress");

endmodule

`default_nettype wire

FILE: tb/tb_card_id_table.sv
module tb_card_id_table;
  import cit_pkg::*;

  // The block ignores this request code and reports a miss.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // Only the low KEY_W bits of an identifier are compared and stored.
  localparam logic [ID_W-1:0] KEY_MASK = {ID_W{1'b1}} >> (ID_W - KEY_W);

  localparam logic [ID_W-1:0] ID_ZERO  = '0;
  localparam logic [ID_W-1:0] ID_ONES  = '1;
  localparam logic [ID_W-1:0] ID_ALT_A = 40'hAA_AAAA_AAAA;
  localparam logic [ID_W-1:0] ID_ALT_B = 40'h55_5555_5555;

  // Upper bound on cycles to wait for outstanding results to arrive.
  localparam int DRAIN_LIMIT = 64 * (MAX_ENTRIES + 4);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [TOTAL_W-1:0]  total;
  } card_result_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [REQ_W-1:0]    req_type;
  logic [ID_W-1:0]     card_id;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  entry_index;
  logic [TOTAL_W-1:0]  entry_total;

  // Shadow copy of the packed identifier list, slot 0 first.
  logic [ID_W-1:0] stored_ids[$];
  card_result_t    pending_results[$];
  card_result_t    oldest_result;

  int error_count = 0;
  int requests_sent = 0;
  int peak_fill = 0;
  int gap_pct = 25;
  int status_tally[4] = '{0, 0, 0, 0};

  card_id_table dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .card_id     (card_id),
    .done        (done),
    .status      (status),
    .entry_index (entry_index),
    .entry_total (entry_total)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one request to the shadow list and return the result it should produce.
  function automatic card_result_t predict_request(input logic [REQ_W-1:0] rt,
                                                   input logic [ID_W-1:0] id);
    card_result_t    res;
    logic [ID_W-1:0] key;
    int              pos;
    key = id & KEY_MASK;
    pos = -1;
    for (int i = 0; i < stored_ids.size(); i++) begin
      if (pos < 0 && stored_ids[i] == key) pos = i;
    end
    res.status = STAT_ABSENT;
    res.index  = '0;
    case (rt)
      REQ_ADD: begin
        // A full table is reported ahead of a duplicate.
        if (stored_ids.size() >= MAX_ENTRIES) begin
          res.status = STAT_FULL;
        end else if (pos >= 0) begin
          res.status = STAT_PRESENT;
        end else begin
          res.index = INDEX_W'(stored_ids.size());
          stored_ids.push_back(key);
          res.status = STAT_OK;
        end
      end
      REQ_FIND: begin
        if (pos >= 0) begin
          res.status = STAT_OK;
          res.index  = INDEX_W'(pos);
        end
      end
      REQ_DELETE: begin
        // Removing a slot moves every later entry down by one.
        if (pos >= 0) begin
          stored_ids.delete(pos);
          res.status = STAT_OK;
          res.index  = INDEX_W'(pos);
        end
      end
      default: begin
      end
    endcase
    res.total = TOTAL_W'(stored_ids.size());
    if (stored_ids.size() > peak_fill) peak_fill = stored_ids.size();
    return res;
  endfunction

  // Mostly stored identifiers, some one-bit near misses, the rest random.
  function automatic logic [ID_W-1:0] pick_card_id();
    logic [63:0]     wide;
    logic [ID_W-1:0] id;
    int              r;
    int              bit_pos;
    wide = {$urandom(), $urandom()};
    id   = wide[ID_W-1:0];
    r    = $urandom_range(0, 9);
    if (stored_ids.size() > 0 && r < 7) begin
      id = stored_ids[$urandom_range(0, stored_ids.size() - 1)];
      if (r == 6) begin
        bit_pos = $urandom_range(0, ID_W - 1);
        id[bit_pos] = ~id[bit_pos];
      end
    end
    return id;
  endfunction

  // Present one request, hold it until it transfers, then maybe idle for a burst.
  task automatic send_request(input logic [REQ_W-1:0] rt, input logic [ID_W-1:0] id);
    start    <= 1'b1;
    req_type <= rt;
    card_id  <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_request(rt, id));
    requests_sent++;
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      // Sometimes let the block go idle first so the gap also lands between requests.
      if ($urandom_range(0, 1) == 1) begin
        while (busy) @(posedge clk);
      end
      repeat ($urandom_range(0, 13)) @(posedge clk);
    end
  endtask

  // Wait until every predicted result has been seen, with a bound.
  task automatic wait_results_drained();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $error("results still outstanding: %0d", pending_results.size());
      error_count++;
    end
  endtask

  // Extremes of the identifier, every request code and each miss case.
  task automatic test_directed();
    send_request(REQ_FIND, ID_ZERO);
    send_request(REQ_DELETE, ID_ONES);
    send_request(REQ_UNUSED, ID_ZERO);
    send_request(REQ_ADD, ID_ZERO);
    send_request(REQ_ADD, ID_ONES);
    send_request(REQ_ADD, ID_ZERO);
    send_request(REQ_ADD, ID_ALT_A);
    send_request(REQ_ADD, ID_ALT_B);
    send_request(REQ_FIND, ID_ONES);
    send_request(REQ_FIND, ID_ZERO);
    send_request(REQ_FIND, ID_ALT_B);
    send_request(REQ_FIND, 40'h00_0000_0001);
    send_request(REQ_UNUSED, ID_ONES);
    send_request(REQ_DELETE, ID_ZERO);
    send_request(REQ_FIND, ID_ONES);
    send_request(REQ_FIND, ID_ALT_B);
    send_request(REQ_DELETE, ID_ALT_B);
    send_request(REQ_DELETE, ID_ALT_A);
    send_request(REQ_DELETE, ID_ALT_A);
    send_request(REQ_ADD, ID_ALT_B);
    send_request(REQ_DELETE, ID_ONES);
    send_request(REQ_DELETE, ID_ALT_B);
  endtask

  // Fill the table, refuse adds when full, work both ends, then empty it.
  task automatic test_full_table();
    logic [63:0] wide;
    while (stored_ids.size() < MAX_ENTRIES) begin
      wide = {$urandom(), $urandom()};
      send_request(REQ_ADD, wide[ID_W-1:0]);
    end
    wide = {$urandom(), $urandom()};
    send_request(REQ_ADD, wide[ID_W-1:0]);
    send_request(REQ_ADD, stored_ids[0]);
    send_request(REQ_FIND, stored_ids[MAX_ENTRIES - 1]);
    send_request(REQ_FIND, stored_ids[0]);
    send_request(REQ_DELETE, stored_ids[MAX_ENTRIES - 1]);
    send_request(REQ_ADD, ID_ONES);
    send_request(REQ_DELETE, stored_ids[0]);
    send_request(REQ_FIND, ID_ONES);
    // Hold off until the table is quiet before emptying it.
    start <= 1'b0;
    wait_results_drained();
    while (stored_ids.size() > 0) begin
      send_request(REQ_DELETE, stored_ids[$urandom_range(0, stored_ids.size() - 1)]);
    end
    send_request(REQ_FIND, ID_ONES);
  endtask

  // Phases of random requests with a shifting mix of adds and idling.
  task automatic test_random_mix(input int item_budget);
    int               add_pct;
    int               r;
    int               sent_here;
    logic [REQ_W-1:0] rt;
    sent_here = 0;
    while (sent_here < item_budget) begin
      case ($urandom_range(0, 2))
        0: add_pct = 75;
        1: add_pct = 45;
        default: add_pct = 20;
      endcase
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      repeat (100) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          rt = REQ_UNUSED;
        end else if (r < 3 + add_pct) begin
          rt = REQ_ADD;
        end else if ($urandom_range(0, 1) == 1) begin
          rt = REQ_FIND;
        end else begin
          rt = REQ_DELETE;
        end
        send_request(rt, pick_card_id());
      end
      sent_here += 100;
      if (sent_here == 500) begin
        start <= 1'b0;
        wait_results_drained();
      end
    end
  endtask

  // Requests held back to back with no idling at all.
  task automatic test_back_to_back(input int item_budget);
    gap_pct = 0;
    repeat (item_budget) begin
      case ($urandom_range(0, 3))
        0, 1: send_request(REQ_ADD, pick_card_id());
        2: send_request(REQ_FIND, pick_card_id());
        default: send_request(REQ_DELETE, pick_card_id());
      endcase
    end
  endtask

  // Compare each result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d index %0d total %0d",
               status, entry_index, entry_total);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        status_tally[oldest_result.status]++;
        if (status !== oldest_result.status) begin
          $error("status: expected %0d, got %0d", oldest_result.status, status);
          error_count++;
        end
        if (entry_index !== oldest_result.index) begin
          $error("entry_index: expected %0d, got %0d", oldest_result.index, entry_index);
          error_count++;
        end
        if (entry_total !== oldest_result.total) begin
          $error("entry_total: expected %0d, got %0d", oldest_result.total, entry_total);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    req_type = REQ_ADD;
    card_id  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random_mix(1000);
    test_back_to_back(100);
    start <= 1'b0;
    wait_results_drained();
    repeat (MAX_ENTRIES + 8) @(posedge clk);
    $display("Sent %0d requests; outcomes: %0d done, %0d full, %0d duplicate, %0d miss.",
             requests_sent, status_tally[STAT_OK], status_tally[STAT_FULL],
             status_tally[STAT_PRESENT], status_tally[STAT_ABSENT]);
    $display("Table fill peaked at %0d of %0d slots; %0d mismatches.",
             peak_fill, MAX_ENTRIES, error_count);
    if (error_count == 0) begin
      $display("card_id_table verification clean");
    end else begin
      $display("card_id_table verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #6000000;
    $display("card_id_table verification failed");
    $finish;
  end

endmodule
